FILE: rtl/core/gpsts_pkg.sv
`timescale 1ns / 1ps
// Package for the GPS event timestamp decoder.
// Holds the front-to-back item type, calendar constants and the month table.
package gpsts_pkg;

    localparam int unsigned NS_W   = 32;
    localparam int unsigned DIVD_W = 62;
    localparam int unsigned DIVS_W = 31;
    localparam int unsigned YPR_W  = 13;

    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [16:0] SEC_PER_DAY = 17'd86400;
    localparam logic [31:0] DAY_OFFSET  = 32'd865565;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    typedef struct packed {
        logic [31:0]        epoch;
        logic [DIVD_W-1:0]  dividend;
        logic [DIVS_W-1:0]  divisor;
        logic               no_div;
    } item_t;

    // days from March 1 to the first of the month; month 0 is December,
    // months 13 to 15 wrap to January to March
    function automatic logic [8:0] month_base(input logic [3:0] mon);
        logic [8:0] b;
        case (mon)
            4'd0:    b = 9'd275;
            4'd1:    b = 9'd306;
            4'd2:    b = 9'd337;
            4'd3:    b = 9'd0;
            4'd4:    b = 9'd31;
            4'd5:    b = 9'd61;
            4'd6:    b = 9'd92;
            4'd7:    b = 9'd122;
            4'd8:    b = 9'd153;
            4'd9:    b = 9'd184;
            4'd10:   b = 9'd214;
            4'd11:   b = 9'd245;
            4'd12:   b = 9'd275;
            4'd13:   b = 9'd306;
            4'd14:   b = 9'd337;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/gpsts_front.sv
`timescale 1ns / 1ps
// Front pipeline: calendar to epoch seconds and tick product for the divider.
// Uses gpsts_pkg.
module gpsts_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           gps_second,
    input  logic [7:0]           leap_seconds,
    input  logic [5:0]           minute,
    input  logic [4:0]           hour,
    input  logic [4:0]           day_of_month,
    input  logic [3:0]           month,
    input  logic [11:0]          year,
    input  logic [31:0]          tick_count,
    input  logic [31:0]          ticks_per_second,
    output logic                 item_valid,
    input  logic                 item_ready,
    output gpsts_pkg::item_t     item
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [12:0] ypr_next, ypr1_reg, ypr2_reg;
    logic [9:0]  mday1_reg, mday2_reg, mday3_reg;
    logic [7:0]  sec1_reg, leap1_reg;
    logic [5:0]  min1_reg;
    logic [4:0]  hour1_reg;
    logic [61:0] prod1_reg, prod2_reg, prod3_reg, prod4_reg;
    logic [30:0] div1_reg, div2_reg, div3_reg, div4_reg;
    logic        nd1_reg, nd2_reg, nd3_reg, nd4_reg;
    logic [31:0] hms2_reg, hms3_reg;
    logic [25:0] r100_2_reg;
    logic [21:0] y365_2_reg;
    logic [31:0] days3_reg, days_next;
    logic [31:0] epoch4_reg;
    logic [6:0]  d100;
    logic [48:0] sec_prod;

    assign adv      = !v4_reg || item_ready;
    assign in_ready = adv;

    always_comb
    begin
        case (month)
            4'd0, 4'd1, 4'd2: ypr_next = {1'b0, year} + 13'd399;
            4'd15:            ypr_next = {1'b0, year} + 13'd401;
            default:          ypr_next = {1'b0, year} + 13'd400;
        endcase
    end

    assign d100 = r100_2_reg[25:gpsts_pkg::RECIP_SHIFT];

    assign days_next = {10'd0, y365_2_reg} + {21'd0, ypr2_reg[12:2]}
                     - {25'd0, d100} + {27'd0, d100[6:2]}
                     + {22'd0, mday2_reg} - 32'd1 - gpsts_pkg::DAY_OFFSET;

    assign sec_prod = days3_reg * gpsts_pkg::SEC_PER_DAY;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ypr1_reg   <= ypr_next;
            mday1_reg  <= {1'b0, gpsts_pkg::month_base(month)} + {5'd0, day_of_month};
            sec1_reg   <= gps_second;
            leap1_reg  <= leap_seconds;
            min1_reg   <= minute;
            hour1_reg  <= hour;
            prod1_reg  <= tick_count * gpsts_pkg::NS_PER_SEC;
            div1_reg   <= ticks_per_second[30:0];
            nd1_reg    <= (ticks_per_second[15:0] == 16'd0);

            ypr2_reg   <= ypr1_reg;
            mday2_reg  <= mday1_reg;
            r100_2_reg <= ypr1_reg * gpsts_pkg::RECIP_100;
            y365_2_reg <= ypr1_reg * 9'd365;
            hms2_reg   <= {15'd0, 17'(hour1_reg) * 17'd3600}
                        + {18'd0, 14'(min1_reg) * 14'd60}
                        + {24'd0, sec1_reg} - {24'd0, leap1_reg};
            prod2_reg  <= prod1_reg;
            div2_reg   <= div1_reg;
            nd2_reg    <= nd1_reg;

            days3_reg  <= days_next;
            mday3_reg  <= mday2_reg;
            hms3_reg   <= hms2_reg;
            prod3_reg  <= prod2_reg;
            div3_reg   <= div2_reg;
            nd3_reg    <= nd2_reg;

            epoch4_reg <= sec_prod[31:0] + hms3_reg;
            prod4_reg  <= prod3_reg;
            div4_reg   <= div3_reg;
            nd4_reg    <= nd3_reg;
        end
    end

    assign item_valid    = v4_reg;
    assign item.epoch    = epoch4_reg;
    assign item.dividend = prod4_reg;
    assign item.divisor  = div4_reg;
    assign item.no_div   = nd4_reg;

endmodule

FILE: rtl/core/gpsts_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front pipeline and the divider back end.
// Uses gpsts_pkg.
module gpsts_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  gpsts_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output gpsts_pkg::item_t pop_item,
    output logic [1:0]       level
);

    gpsts_pkg::item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rptr_reg];
    assign level      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_item;
    end

endmodule

FILE: rtl/core/gpsts_back.sv
`timescale 1ns / 1ps
// Back end: restoring divider for nanoseconds, total nanoseconds, output register.
// Uses gpsts_pkg.
module gpsts_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  gpsts_pkg::item_t item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      epoch_seconds,
    output logic [31:0]      nanoseconds,
    output logic [63:0]      total_nanoseconds,
    output logic             fraction_overflow
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [31:0] epoch_reg, lo_reg;
    logic [30:0] rem_reg, dvs_reg;
    logic        ovf_reg;
    logic [63:0] prod_reg;
    logic [31:0] trial;
    logic        fire;
    logic        sat;
    logic        load_out;

    assign item_ready = (state_reg == ST_IDLE);
    assign fire       = item_valid && item_ready;
    assign sat        = ({1'b0, item.dividend[61:32]} >= item.divisor);
    assign trial      = {rem_reg, lo_reg[31]};
    assign load_out   = (state_reg == ST_SUM) && (!out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                    state_next = (item.no_div || sat) ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == 5'd31)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
                cnt_reg <= 5'd0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + 5'd1;
            if (load_out)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            epoch_reg <= item.epoch;
            dvs_reg   <= item.divisor;
            rem_reg   <= {1'b0, item.dividend[61:32]};
            if (item.no_div)
            begin
                lo_reg  <= 32'd0;
                ovf_reg <= 1'b0;
            end
            else if (sat)
            begin
                lo_reg  <= 32'hFFFF_FFFF;
                ovf_reg <= 1'b1;
            end
            else
            begin
                lo_reg  <= item.dividend[31:0];
                ovf_reg <= 1'b0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= 31'(trial - {1'b0, dvs_reg});
                lo_reg  <= {lo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[30:0];
                lo_reg  <= {lo_reg[30:0], 1'b0};
            end
        end
        if (state_reg == ST_MUL)
            prod_reg <= epoch_reg * gpsts_pkg::NS_PER_SEC;
        if (load_out)
        begin
            epoch_seconds     <= epoch_reg;
            nanoseconds       <= lo_reg;
            total_nanoseconds <= prod_reg + {32'd0, lo_reg};
            fraction_overflow <= ovf_reg;
        end
    end

endmodule

FILE: rtl/core/gps_event_timestamp_decoder.sv
`timescale 1ns / 1ps
// GPS event timestamp decoder top level: front pipeline, queue, divider back end.
// Uses gpsts_pkg, gpsts_front, gpsts_queue, gpsts_back.
//
//   channel | signals              | payload
//   input   | in_valid / in_ready  | gps_second .. ticks_per_second
//   output  | out_valid / out_ready| epoch_seconds, nanoseconds, total_nanoseconds,
//           |                      | fraction_overflow
//
// Front is a 4-stage pipeline taking one transfer per cycle when not stalled.
// Back runs a 32-step restoring divider for each item with a division and skips it
// when the low 16 bits of the period are zero or the quotient saturates.
// Back takes a new item only after finishing the last; the divider sets the rate.
// Reset clears all valid and state bits; no clearing pass.
// Stalls on the output hold the back end; the queue lets the front keep going.
module gps_event_timestamp_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  gps_second,
    input  logic [7:0]  leap_seconds,
    input  logic [5:0]  minute,
    input  logic [4:0]  hour,
    input  logic [4:0]  day_of_month,
    input  logic [3:0]  month,
    input  logic [11:0] year,
    input  logic [31:0] tick_count,
    input  logic [31:0] ticks_per_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] epoch_seconds,
    output logic [31:0] nanoseconds,
    output logic [63:0] total_nanoseconds,
    output logic        fraction_overflow
);

    logic             f_valid, f_ready, b_valid, b_ready;
    gpsts_pkg::item_t f_item, b_item;
    logic [1:0]       q_level;

    gpsts_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .gps_second       (gps_second),
        .leap_seconds     (leap_seconds),
        .minute           (minute),
        .hour             (hour),
        .day_of_month     (day_of_month),
        .month            (month),
        .year             (year),
        .tick_count       (tick_count),
        .ticks_per_second (ticks_per_second),
        .item_valid       (f_valid),
        .item_ready       (f_ready),
        .item             (f_item)
    );

    gpsts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item),
        .level      (q_level)
    );

    gpsts_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (b_valid),
        .item_ready        (b_ready),
        .item              (b_item),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .epoch_seconds     (epoch_seconds),
        .nanoseconds       (nanoseconds),
        .total_nanoseconds (total_nanoseconds),
        .fraction_overflow (fraction_overflow)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level != 2'd3)
        else $error("queue level out of range");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fraction_overflow |-> nanoseconds == 32'hFFFF_FFFF)
        else $error("overflow without saturated nanoseconds");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_nanoseconds
            == epoch_seconds * 64'd1000000000 + {32'd0, nanoseconds})
        else $error("total nanoseconds mismatch");

endmodule

FILE: bench/tb_gps_event_timestamp_decoder.sv
`timescale 1ns / 1ps
// Testbench for gps_event_timestamp_decoder: directed table plus random GPS headers,
// checked against an in-bench calendar and fraction calculator. Needs only the RTL.
module tb_gps_event_timestamp_decoder;

    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  leap;
        logic [5:0]  mins;
        logic [4:0]  hrs;
        logic [4:0]  day;
        logic [3:0]  mon;
        logic [11:0] yr;
        logic [31:0] ticks;
        logic [31:0] tps;
    } hdr_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [31:0] ns;
        logic [63:0] total;
        logic        ovf;
    } stamp_t;

    typedef struct {
        hdr_t   h;
        logic   known;
        stamp_t s;
    } row_t;

    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    hdr_t        cur;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] epoch_seconds;
    logic [31:0] nanoseconds;
    logic [63:0] total_nanoseconds;
    logic        fraction_overflow;

    stamp_t stamp_q[$];
    int     errors = 0;
    int     table_errs;
    int     idle_in_pct;
    int     idle_out_pct;
    bit     hold_req;
    bit     hold_done = 1'b0;
    int     hold_cycles = 0;
    int     quiet_cycles = 0;
    bit     done;

    gps_event_timestamp_decoder dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .gps_second(cur.sec), .leap_seconds(cur.leap), .minute(cur.mins),
        .hour(cur.hrs), .day_of_month(cur.day), .month(cur.mon), .year(cur.yr),
        .tick_count(cur.ticks), .ticks_per_second(cur.tps),
        .out_valid(out_valid), .out_ready(out_ready), .epoch_seconds(epoch_seconds),
        .nanoseconds(nanoseconds), .total_nanoseconds(total_nanoseconds),
        .fraction_overflow(fraction_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint days_since_epoch(longint y, longint m, longint d);
        longint era, yoe, doy, doe, mp;
        if (m <= 2)
            y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp = (m > 2) ? (m - 3) : (m + 9);
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic stamp_t timestamp_of(hdr_t h);
        stamp_t s;
        longint y, m, secs;
        logic [63:0] period, q;
        y = h.yr;
        m = h.mon;
        if (m == 0)
        begin
            m = 12;
            y = y - 1;
        end
        else if (m > 12)
        begin
            m = m - 12;
            y = y + 1;
        end
        secs = days_since_epoch(y, m, h.day) * 86400 + longint'(h.hrs) * 3600
             + longint'(h.mins) * 60 + longint'(h.sec) - longint'(h.leap);
        s.epoch = secs[31:0];
        s.ns = '0;
        s.ovf = 1'b0;
        if (h.tps[15:0] != 0)
        begin
            period = {33'd0, h.tps[30:0]};
            q = (64'(h.ticks) * 64'd1000000000) / period;
            if (q > 64'hFFFF_FFFF)
            begin
                s.ns = '1;
                s.ovf = 1'b1;
            end
            else
                s.ns = q[31:0];
        end
        s.total = 64'(s.epoch) * 64'd1000000000 + 64'(s.ns);
        return s;
    endfunction

    function automatic hdr_t mk(int sec, int leap, int mins, int hrs, int day, int mon,
                                int yr, logic [31:0] ticks, logic [31:0] tps);
        hdr_t h;
        h.sec = 8'(sec); h.leap = 8'(leap); h.mins = 6'(mins); h.hrs = 5'(hrs);
        h.day = 5'(day); h.mon = 4'(mon); h.yr = 12'(yr); h.ticks = ticks; h.tps = tps;
        return h;
    endfunction

    function automatic hdr_t rand_header();
        hdr_t h;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        h = raw[111:0];
        if ($urandom_range(0, 9) < 7)
        begin
            h.sec = 8'($urandom_range(0, 59));
            h.leap = 8'($urandom_range(0, 20));
            h.mins = 6'($urandom_range(0, 59));
            h.hrs = 5'($urandom_range(0, 23));
            h.day = 5'($urandom_range(1, 28));
            h.mon = 4'($urandom_range(1, 12));
            h.yr = 12'($urandom_range(1970, 2105));
            case ($urandom_range(0, 3))
                0: h.tps = 32'($urandom_range(1000, 300000000));
                1: h.tps = {1'($urandom_range(0, 1)), 15'($urandom), 16'd0};
                2: h.tps = 32'($urandom_range(1, 65535));
                default: h.tps = $urandom;
            endcase
            if ($urandom_range(0, 1) && h.tps[30:0] != 0)
                h.ticks = $urandom_range(0, h.tps[30:0]);
        end
        return h;
    endfunction

    task automatic send(hdr_t h);
        cur <= h;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        stamp_q.push_back(timestamp_of(h));
    endtask

    task automatic send_idle(hdr_t h);
        if ($urandom_range(1, 100) <= idle_in_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        send(h);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (stamp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int pin, int pout, int n);
        idle_in_pct = pin;
        idle_out_pct = pout;
        repeat (n) send_idle(rand_header());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            if (hold_cycles == HOLD_LEN - 1)
                hold_done <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else
            out_ready <= ($urandom_range(1, 100) > idle_out_pct);
    end

    always @(posedge clk)
    begin
        stamp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (stamp_q.size() == 0)
            begin
                $display("%0t unexpected transfer epoch=%h", $time, epoch_seconds);
                errors++;
            end
            else
            begin
                e = stamp_q.pop_front();
                if (epoch_seconds !== e.epoch || nanoseconds !== e.ns
                    || total_nanoseconds !== e.total || fraction_overflow !== e.ovf)
                begin
                    $display("%0t mismatch exp %h %h %h %b got %h %h %h %b", $time,
                             e.epoch, e.ns, e.total, e.ovf, epoch_seconds, nanoseconds,
                             total_nanoseconds, fraction_overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (!done && quiet_cycles >= WDOG_LIMIT)
        begin
            $display("tb_gps_event_timestamp_decoder: FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t table_rows[$];
        row_t r;
        stamp_t s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cur = '0;
        table_errs = 0;
        idle_in_pct = 0;
        idle_out_pct = 0;
        hold_req = 1'b0;
        done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        s = '0;
        r.known = 1'b1; r.s = s;
        r.h = mk(0, 0, 0, 0, 1, 1, 1970, 0, 0); table_rows.push_back(r);
        s.ns = '1; s.ovf = 1'b1; s.total = 64'hFFFF_FFFF;
        r.h = mk(0, 0, 0, 0, 1, 1, 1970, 32'hFFFF_FFFF, 32'h0000_0001); r.s = s;
        table_rows.push_back(r);
        s = '0; s.epoch = 32'd1; s.total = 64'd1000000000;
        r.h = mk(1, 0, 0, 0, 1, 1, 1970, 32'hFFFF_FFFF, 32'hFFFF_0000); r.s = s;
        table_rows.push_back(r);
        s = '0; s.epoch = 32'hFFFF_FFFF; s.total = 64'hFFFF_FFFF * 64'd1000000000;
        r.h = mk(0, 1, 0, 0, 1, 1, 1970, 0, 32'd100); r.s = s;
        table_rows.push_back(r);
        r.known = 1'b0; r.s = '0;
        r.h = mk(255, 255, 63, 31, 31, 15, 4095, '1, '1); table_rows.push_back(r);
        r.h = mk(0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0001); table_rows.push_back(r);
        r.h = mk(59, 18, 59, 23, 31, 12, 2105, 32'd5, 32'd10); table_rows.push_back(r);
        r.h = mk(30, 18, 30, 12, 29, 2, 2024, 32'd99999999, 32'd100000000);
        table_rows.push_back(r);
        r.h = mk(0, 0, 0, 0, 1, 13, 2099, 32'd100000000, 32'd100000000);
        table_rows.push_back(r);
        r.h = mk(0, 0, 0, 0, 1, 14, 1999, 32'd150000000, 32'd100000000);
        table_rows.push_back(r);
        r.h = mk(0, 0, 0, 0, 1, 0, 2000, 32'd4, 32'd1); table_rows.push_back(r);
        r.h = mk(10, 0, 0, 0, 1, 3, 1900, 32'd7, 32'd3); table_rows.push_back(r);
        r.h = mk(0, 0, 0, 0, 29, 2, 2100, 32'hAAAA_5555, 32'h5555_AAAA);
        table_rows.push_back(r);
        r.h = mk(170, 85, 42, 21, 10, 10, 2730, 32'h5555_AAAA, 32'h2AAA_5555);
        table_rows.push_back(r);

        foreach (table_rows[i])
        begin
            if (table_rows[i].known && timestamp_of(table_rows[i].h) !== table_rows[i].s)
            begin
                $display("%0t table row %0d exp %h got %h", $time, i,
                         table_rows[i].s, timestamp_of(table_rows[i].h));
                table_errs++;
            end
            send(table_rows[i].h);
        end
        drain();

        run_phase(0, 0, 150);
        hold_req = 1'b1;
        run_phase(0, 0, 40);
        drain();
        run_phase(45, 0, 150);
        run_phase(0, 45, 150);
        run_phase(32, 32, 150);
        drain();
        idle_out_pct = 0;
        repeat (100) @(posedge clk);
        done = 1'b1;
        if (errors == 0 && table_errs == 0 && stamp_q.size() == 0)
            $display("tb_gps_event_timestamp_decoder: PASS");
        else
            $display("tb_gps_event_timestamp_decoder: FAIL");
        $finish;
    end

endmodule
